FILE: design/ipclass_pkg.sv
// Shared types and constants of the address text classifier.
// No dependencies; the front end, the back end and the top level import this package.
package ipclass_pkg;

  // Character codes of the two separators.
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Group and separator limits.
  localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
  localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [2:0] V4_SEPS       = 3'd3;
  localparam logic [3:0] V6_SEPS       = 4'd7;

  // Saturation points of the counters.
  localparam logic [2:0] LEN_SAT   = 3'd7;
  localparam logic [2:0] DOT_SAT   = 3'd7;
  localparam logic [3:0] COLON_SAT = 4'd15;
  localparam logic [9:0] VALUE_SAT = 10'd1023;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_V4   = 2'd1;
  localparam logic [1:0] VERDICT_V6   = 2'd2;

  // Character class decided by the front end.
  typedef enum logic [2:0] {
    CLS_DOT,
    CLS_COLON,
    CLS_DIGIT,
    CLS_HEX,
    CLS_OTHER
  } cls_t;

  // One classified character as it sits in the queue.
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

endpackage

FILE: design/ipclass_in_if.sv
// Input channel of the address text classifier: one character per item.
// No dependencies.
interface ipclass_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink   (input valid, input ch, input is_last, output ready);
endinterface

FILE: design/ipclass_out_if.sv
// Result channel of the address text classifier: one verdict per item.
// No dependencies.
interface ipclass_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

FILE: design/ipclass_front.sv
// Front end: accepts characters, classifies them and queues the tokens.
// Depends on ipclass_pkg and ipclass_in_if.
module ipclass_front
  import ipclass_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  ipclass_in_if.sink          in_chan,
  output logic                tok_valid,
  input  logic                tok_ready,
  output tok_t                tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t            q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;
  tok_t            tok_in;

  // Classify the incoming character.
  always_comb begin
    tok_in.last  = in_chan.is_last;
    tok_in.digit = in_chan.ch[3:0];
    if (in_chan.ch == DOT_CHAR) begin
      tok_in.cls = CLS_DOT;
    end else if (in_chan.ch == COLON_CHAR) begin
      tok_in.cls = CLS_COLON;
    end else if (in_chan.ch >= 8'h30 && in_chan.ch <= 8'h39) begin
      tok_in.cls = CLS_DIGIT;
    end else if ((in_chan.ch >= 8'h41 && in_chan.ch <= 8'h46) ||
                 (in_chan.ch >= 8'h61 && in_chan.ch <= 8'h66)) begin
      tok_in.cls = CLS_HEX;
    end else begin
      tok_in.cls = CLS_OTHER;
    end
  end

  assign in_chan.ready = (cnt_r != CW'(DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign tok_valid     = (cnt_r != '0);
  assign pop           = tok_valid && tok_ready;
  assign tok           = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= tok_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

  a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valid && !tok_ready) |=> (tok_valid && $stable(tok)))
    else $error("waiting token changed");

endmodule

FILE: design/ipclass_back.sv
// Back end: walks the classified tokens, tracks IPv4/IPv6 validity and
// registers the verdict. Depends on ipclass_pkg and ipclass_out_if.
module ipclass_back
  import ipclass_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  tok_t          tok,
  ipclass_out_if.source out_chan
);

  logic        v4_r, v4_nxt;
  logic        v6_r, v6_nxt;
  logic [2:0]  dot_r, dot_nxt;
  logic [3:0]  col_r, col_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [9:0]  val_r, val_nxt;
  logic        lz_r, lz_nxt;
  logic [13:0] prod;
  logic [1:0]  verdict;
  logic        out_valid_r;
  logic [1:0]  verdict_r;
  logic        pop;

  // A last token needs the output register free; others pass freely.
  assign tok_ready = !tok.last || !out_valid_r || out_chan.ready;
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    v4_nxt  = v4_r;
    v6_nxt  = v6_r;
    dot_nxt = dot_r;
    col_nxt = col_r;
    len_nxt = len_r;
    val_nxt = val_r;
    lz_nxt  = lz_r;
    prod    = {4'b0, val_r} * 14'd10 + {10'b0, tok.digit};
    unique case (tok.cls)
      CLS_DOT: begin
        v6_nxt = 1'b0;
        if (len_r == '0 || dot_r >= V4_SEPS) v4_nxt = 1'b0;
        if (dot_r < DOT_SAT) dot_nxt = 3'(dot_r + 1'b1);
        len_nxt = '0;
        val_nxt = '0;
        lz_nxt  = 1'b0;
      end
      CLS_COLON: begin
        v4_nxt = 1'b0;
        if (len_r == '0 || col_r >= V6_SEPS) v6_nxt = 1'b0;
        if (col_r < COLON_SAT) col_nxt = 4'(col_r + 1'b1);
        len_nxt = '0;
        val_nxt = '0;
        lz_nxt  = 1'b0;
      end
      CLS_DIGIT: begin
        if (len_r == '0) begin
          lz_nxt = (tok.digit == 4'd0);
        end else if (lz_r) begin
          v4_nxt = 1'b0;
        end
        val_nxt = (prod > {4'b0, VALUE_SAT}) ? VALUE_SAT : prod[9:0];
        if (val_nxt > V4_MAX_VALUE) v4_nxt = 1'b0;
        if (len_r < LEN_SAT) len_nxt = 3'(len_r + 1'b1);
      end
      CLS_HEX: begin
        v4_nxt = 1'b0;
        if (len_r < LEN_SAT) len_nxt = 3'(len_r + 1'b1);
      end
      default: begin
        v4_nxt = 1'b0;
        v6_nxt = 1'b0;
      end
    endcase
    if (len_nxt > V4_MAX_DIGITS) v4_nxt = 1'b0;
    if (len_nxt > V6_MAX_DIGITS) v6_nxt = 1'b0;

    if (v4_nxt && dot_nxt == V4_SEPS && len_nxt != '0) begin
      verdict = VERDICT_V4;
    end else if (v6_nxt && col_nxt == V6_SEPS && len_nxt != '0) begin
      verdict = VERDICT_V6;
    end else begin
      verdict = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b1;
      v6_r  <= 1'b1;
      dot_r <= '0;
      col_r <= '0;
      len_r <= '0;
      val_r <= '0;
      lz_r  <= 1'b0;
    end else if (pop) begin
      if (tok.last) begin
        v4_r  <= 1'b1;
        v6_r  <= 1'b1;
        dot_r <= '0;
        col_r <= '0;
        len_r <= '0;
        val_r <= '0;
        lz_r  <= 1'b0;
      end else begin
        v4_r  <= v4_nxt;
        v6_r  <= v6_nxt;
        dot_r <= dot_nxt;
        col_r <= col_nxt;
        len_r <= len_nxt;
        val_r <= val_nxt;
        lz_r  <= lz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && tok.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      verdict_r <= verdict;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.verdict = verdict_r;

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && tok.last) |=> (dot_r == '0 && col_r == '0 && len_r == '0 && v4_r && v6_r))
    else $error("string state not cleared after verdict");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (verdict_r == VERDICT_NONE || verdict_r == VERDICT_V4 ||
                     verdict_r == VERDICT_V6))
    else $error("verdict code out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(pop && tok.last))
    else $error("pending verdict overwritten");

endmodule

FILE: design/ip_address_text_classifier_top.sv
// Top level of the IPv4/IPv6 address text classifier.
// Depends on ipclass_pkg, ipclass_in_if, ipclass_out_if, ipclass_front, ipclass_back.
//
//   channel   dir  payload                       item
//   in_chan   in   ch[7:0], is_last              one character of the string
//   out_chan  out  verdict[1:0]                  0 neither, 1 IPv4, 2 IPv6
//
// Cycles: sustained one character per cycle while out_chan takes verdicts; a last
//   character is written into the token queue, then the back end registers its
//   verdict into verdict_r, which drives out_chan; only tokens queued ahead delay it.
// The figure is set by the per-character state update in the back end, which
//   retires one queued token per cycle unless a last token waits on a full output register.
// Reset: rst_n low for one clock empties the queue, drops any pending verdict
//   and returns the string state to "both kinds possible".
// Stalls: in_chan.ready depends only on queue fill; a stalled out_chan holds
//   the verdict, and the back end keeps consuming non-final characters.
module ip_address_text_classifier_top
  import ipclass_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  ipclass_in_if.sink    in_chan,
  ipclass_out_if.source out_chan
);

  logic tok_valid;
  logic tok_ready;
  tok_t tok;

  // Front: classify each character and hold it in the token queue.
  ipclass_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // Back: advance the validity state and register the verdict.
  ipclass_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .out_chan  (out_chan)
  );

endmodule
